// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/dbtf_pkg.sv -----
// ----------------------------------------------------------------------------
// dbtf_pkg
// shared types and constants of the detection box transform and filter
// ----------------------------------------------------------------------------
package dbtf_pkg;

    // grid and fixed-point constants
    localparam int GRID_HALF = 4096;
    localparam int GRID_FULL = 8192;
    localparam int UNIT_SH   = 13;   // one scene unit for positions and sizes
    localparam int CUNIT_SH  = 14;   // one scene unit for centres

    // configuration port
    localparam int PADDR_W = 6;
    localparam int PDATA_W = 64;

    // stream widths
    localparam int S_TDATA_W = 96;
    localparam int S_TUSER_W = 8;
    localparam int M_TDATA_W = 112;
    localparam int M_TUSER_W = 9;

    typedef enum logic [2:0] {
        REG_ROTATION,
        REG_MIN_CONFIDENCE,
        REG_MIN_SIZE,
        REG_MAX_SIZE,
        REG_AREA_BOX,
        REG_IGNORE_BOX,
        REG_CLASS_ACTIVE_MASK,
        REG_CLASS_COUNT
    } reg_idx_t;

    typedef enum logic [1:0] {
        ROT_NONE,
        ROT_90,
        ROT_180,
        ROT_270
    } rot_t;

    typedef struct packed {
        rot_t        rotation;
        logic [6:0]  min_confidence;
        logic [19:0] min_size;
        logic [19:0] max_size;
        logic [39:0] area_box;
        logic [39:0] ignore_box;
        logic [63:0] class_active_mask;
        logic [6:0]  class_count;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        rotation:          ROT_NONE,
        min_confidence:    7'd0,
        min_size:          20'd10250,
        max_size:          20'd922500,
        area_box:          40'd1074790400000,
        ignore_box:        40'd0,
        class_active_mask: 64'hFFFF_FFFF_FFFF_FFFF,
        class_count:       7'd64
    };

    typedef struct packed {
        logic signed [13:0] left_edge;
        logic signed [13:0] top_edge;
        logic signed [13:0] right_edge;
        logic signed [13:0] bottom_edge;
        logic [31:0]        object_id;
        logic [7:0]         class_index;
        logic [6:0]         score;
        logic               last_of_scene;
    } item_t;

    typedef struct packed {
        logic               keep;
        logic signed [11:0] box_x;
        logic signed [11:0] box_y;
        logic signed [11:0] box_w;
        logic signed [11:0] box_h;
        logic signed [11:0] centre_x;
        logic signed [11:0] centre_y;
        logic [31:0]        out_id;
        logic [7:0]         out_class;
        logic [6:0]         out_score;
        logic               out_last;
    } result_t;

endpackage

// ----- rtl/dbtf_cfg.sv -----
// ----------------------------------------------------------------------------
// dbtf_cfg
// register file behind the configuration port, write and read back
// ----------------------------------------------------------------------------
module dbtf_cfg
    import dbtf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:3]);
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_ROTATION:          cfg_next.rotation          = rot_t'(pwdata[1:0]);
                REG_MIN_CONFIDENCE:    cfg_next.min_confidence    = pwdata[6:0];
                REG_MIN_SIZE:          cfg_next.min_size          = pwdata[19:0];
                REG_MAX_SIZE:          cfg_next.max_size          = pwdata[19:0];
                REG_AREA_BOX:          cfg_next.area_box          = pwdata[39:0];
                REG_IGNORE_BOX:        cfg_next.ignore_box        = pwdata[39:0];
                REG_CLASS_ACTIVE_MASK: cfg_next.class_active_mask = pwdata;
                REG_CLASS_COUNT:       cfg_next.class_count       = pwdata[6:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read back mux
    always_comb
    begin
        unique case (reg_idx)
            REG_ROTATION:          prdata = PDATA_W'(cfg_reg.rotation);
            REG_MIN_CONFIDENCE:    prdata = PDATA_W'(cfg_reg.min_confidence);
            REG_MIN_SIZE:          prdata = PDATA_W'(cfg_reg.min_size);
            REG_MAX_SIZE:          prdata = PDATA_W'(cfg_reg.max_size);
            REG_AREA_BOX:          prdata = PDATA_W'(cfg_reg.area_box);
            REG_IGNORE_BOX:        prdata = PDATA_W'(cfg_reg.ignore_box);
            REG_CLASS_ACTIVE_MASK: prdata = cfg_reg.class_active_mask;
            REG_CLASS_COUNT:       prdata = PDATA_W'(cfg_reg.class_count);
        endcase
    end

endmodule

// ----- rtl/dbtf_core.sv -----
// ----------------------------------------------------------------------------
// dbtf_core
// grid mapping, rotation, scaling, centre and keep tests for one detection
// ----------------------------------------------------------------------------
module dbtf_core
    import dbtf_pkg::*;
#(
    parameter int SCENE_RANGE = 1000,
    parameter int MAX_CLASSES = 64
)
(
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

    // numerators over 8192 (centres over 16384) stay below 2^(NUM_W-1)
    localparam int NUM_W = $clog2(SCENE_RANGE + 1) + 19;
    localparam int SEL_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam logic signed [NUM_W-1:0] SCALE  = NUM_W'(SCENE_RANGE);
    localparam logic signed [NUM_W-1:0] FULL   = NUM_W'(SCENE_RANGE * GRID_FULL);
    localparam logic signed [NUM_W-1:0] SAT_HI = NUM_W'(2047);
    localparam logic signed [NUM_W-1:0] SAT_LO = NUM_W'(-2048);
    localparam logic [7:0] CNT_MAX = 8'(MAX_CLASSES);

    // divide by a power of two, rounding toward zero
    function automatic logic signed [NUM_W-1:0] div_pow2(
        input logic signed [NUM_W-1:0] v,
        input int sh
    );
        logic signed [NUM_W-1:0] bias;
        bias = v[NUM_W-1] ? ((NUM_W'(1) <<< sh) - NUM_W'(1)) : '0;
        return (v + bias) >>> sh;
    endfunction

    // clamp to the 12-bit signed output range
    function automatic logic [11:0] sat12(input logic signed [NUM_W-1:0] v);
        logic [11:0] r;
        if (v > SAT_HI)
            r = 12'h7FF;
        else if (v < SAT_LO)
            r = 12'h800;
        else
            r = v[11:0];
        return r;
    endfunction

    // ten-bit limit scaled to a numerator
    function automatic logic signed [NUM_W-1:0] lim(input logic [9:0] f, input int sh);
        logic signed [NUM_W-1:0] l;
        l = $signed(NUM_W'(f));
        return l <<< sh;
    endfunction

    logic signed [15:0] xg, yg, x2g, y2g, wg, hg, xg_r, yg_r;
    logic signed [NUM_W-1:0] xs, ys, ws, hs;
    logic signed [NUM_W-1:0] x_rot, y_rot, w_rot, h_rot, cx, cy;
    logic [7:0] cnt, sel;
    logic class_on, score_ok, size_ok, area_ok, ignore_hit;

    // edges onto the 8192 grid
    assign xg  = 16'(item.left_edge) + 16'(GRID_HALF);
    assign yg  = 16'(GRID_HALF) - 16'(item.top_edge);
    assign x2g = 16'(item.right_edge) + 16'(GRID_HALF);
    assign y2g = 16'(GRID_HALF) - 16'(item.bottom_edge);
    assign wg  = x2g - xg;
    assign hg  = y2g - yg;

    // half turn on the grid, size unchanged
    assign xg_r = (cfg.rotation == ROT_180) ? 16'(GRID_FULL) - x2g : xg;
    assign yg_r = (cfg.rotation == ROT_180) ? 16'(GRID_FULL) - y2g : yg;

    // scale to scene units, constant multiplier
    assign xs = NUM_W'(xg_r) * SCALE;
    assign ys = NUM_W'(yg_r) * SCALE;
    assign ws = NUM_W'(wg) * SCALE;
    assign hs = NUM_W'(hg) * SCALE;

    // quarter turns
    always_comb
    begin
        case (cfg.rotation)
            ROT_90:
            begin
                w_rot = div_pow2(hs, UNIT_SH) <<< UNIT_SH;
                h_rot = ws;
                x_rot = FULL - ys - w_rot;
                y_rot = div_pow2(xs, UNIT_SH) <<< UNIT_SH;
            end
            ROT_270:
            begin
                w_rot = div_pow2(hs, UNIT_SH) <<< UNIT_SH;
                h_rot = ws;
                y_rot = FULL - xs - h_rot;
                x_rot = div_pow2(ys, UNIT_SH) <<< UNIT_SH;
            end
            default:
            begin
                x_rot = xs;
                y_rot = ys;
                w_rot = ws;
                h_rot = hs;
            end
        endcase
    end

    // doubled centre
    assign cx = (x_rot <<< 1) + w_rot;
    assign cy = (y_rot <<< 1) + h_rot;

    // class lookup, out-of-range ids fall on the last class
    always_comb
    begin
        if (cfg.class_count == 7'd0)
            cnt = 8'd1;
        else if (8'(cfg.class_count) > CNT_MAX)
            cnt = CNT_MAX;
        else
            cnt = 8'(cfg.class_count);
        sel = (item.class_index < cnt) ? item.class_index : cnt - 8'd1;
    end
    assign class_on = cfg.class_active_mask[sel[SEL_W-1:0]];

    assign score_ok = !(item.score < cfg.min_confidence);

    // size window
    assign size_ok = !(w_rot > lim(cfg.max_size[9:0], UNIT_SH) ||
                       h_rot > lim(cfg.max_size[19:10], UNIT_SH) ||
                       w_rot < lim(cfg.min_size[9:0], UNIT_SH) ||
                       h_rot < lim(cfg.min_size[19:10], UNIT_SH));

    // area of interest
    assign area_ok = !(cx < lim(cfg.area_box[9:0], CUNIT_SH) ||
                       cx > lim(cfg.area_box[29:20], CUNIT_SH) ||
                       cy < lim(cfg.area_box[19:10], CUNIT_SH) ||
                       cy > lim(cfg.area_box[39:30], CUNIT_SH));

    // ignore region, left edge open
    assign ignore_hit = (cx >  lim(cfg.ignore_box[9:0], CUNIT_SH)) &&
                        (cx <= lim(cfg.ignore_box[29:20], CUNIT_SH)) &&
                        (cy >= lim(cfg.ignore_box[19:10], CUNIT_SH)) &&
                        (cy <= lim(cfg.ignore_box[39:30], CUNIT_SH));

    // result fields
    always_comb
    begin
        res.keep      = class_on && score_ok && size_ok && area_ok && !ignore_hit;
        res.box_x     = sat12(div_pow2(x_rot, UNIT_SH));
        res.box_y     = sat12(div_pow2(y_rot, UNIT_SH));
        res.box_w     = sat12(div_pow2(w_rot, UNIT_SH));
        res.box_h     = sat12(div_pow2(h_rot, UNIT_SH));
        res.centre_x  = sat12(div_pow2(cx, CUNIT_SH));
        res.centre_y  = sat12(div_pow2(cy, CUNIT_SH));
        res.out_id    = item.object_id;
        res.out_class = item.class_index;
        res.out_score = item.score;
        res.out_last  = item.last_of_scene;
    end

endmodule

// ----- rtl/detection_box_transform_filter_top.sv -----
// ----------------------------------------------------------------------------
// detection_box_transform_filter_top: input register, one pass of logic, result register
// throughput one detection per cycle while the receiver takes results (m_tready high)
// async reset clears both stage valids and loads register defaults; no clearing pass
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module detection_box_transform_filter_top
    import dbtf_pkg::*;
#(
    parameter int SCENE_RANGE = 1000,
    parameter int MAX_CLASSES = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // detection input
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // left_edge, top_edge, right_edge, bottom_edge, object_id, score, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // class_index
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 s_tlast,
    // result output
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // box_x, box_y, box_w, box_h, centre_x, centre_y, out_id, out_score, zero pad
    output logic [M_TDATA_W-1:0] m_tdata,
    // keep, out_class
    output logic [M_TUSER_W-1:0] m_tuser,
    output logic                 m_tlast,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    cfg_t    cfg;
    item_t   in_item;
    item_t   in_item_reg;
    logic    in_valid_reg;
    logic    in_valid_next;
    result_t core_res;
    result_t out_res_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    out_ready;
    logic    in_xfer;
    logic    out_load;

    dbtf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // unpack input transfer
    assign in_item.left_edge     = s_tdata[13:0];
    assign in_item.top_edge      = s_tdata[27:14];
    assign in_item.right_edge    = s_tdata[41:28];
    assign in_item.bottom_edge   = s_tdata[55:42];
    assign in_item.object_id     = s_tdata[87:56];
    assign in_item.score         = s_tdata[94:88];
    assign in_item.class_index   = s_tuser;
    assign in_item.last_of_scene = s_tlast;

    // handshake: each stage moves when the one after it can take
    assign out_ready      = !out_valid_reg || m_tready;
    assign s_tready       = !in_valid_reg || out_ready;
    assign in_xfer        = s_tvalid && s_tready;
    assign out_load       = in_valid_reg && out_ready;
    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = out_ready ? in_valid_reg : out_valid_reg;

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_item_reg <= in_item;
        end
    end

    dbtf_core #(
        .SCENE_RANGE (SCENE_RANGE),
        .MAX_CLASSES (MAX_CLASSES)
    ) u_core (
        .item (in_item_reg),
        .cfg  (cfg),
        .res  (core_res)
    );

    // result register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_res_reg <= core_res;
        end
    end

    // pack result transfer
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_res_reg.out_score, out_res_reg.out_id,
                       out_res_reg.centre_y, out_res_reg.centre_x,
                       out_res_reg.box_h, out_res_reg.box_w,
                       out_res_reg.box_y, out_res_reg.box_x};
    assign m_tuser  = {out_res_reg.out_class, out_res_reg.keep};
    assign m_tlast  = out_res_reg.out_last;

    // pipeline checks
    `ASSERT_NEXT(a_accept_lands, clk, rst_n, in_xfer, in_valid_reg,
                 "accepted item not held in input stage")
    `ASSERT_NEXT(a_stage_holds, clk, rst_n, in_valid_reg && !out_ready,
                 in_valid_reg && $stable(in_item_reg), "stalled input stage lost or changed its item")
    `ASSERT_NEXT(a_advance, clk, rst_n, out_load, m_tvalid,
                 "item moved out of input stage but no result shown")
    `ASSERT_IMPL(a_full_blocks, clk, rst_n, in_valid_reg && out_valid_reg && !m_tready,
                 !s_tready, "input taken while both stages are full and stalled")

endmodule

// ----- dv/detection_box_transform_filter_checker.sv -----
// ----------------------------------------------------------------------------
// detection_box_transform_filter_checker
// follows register writes on the configuration port, predicts one result
// for every detection transfer and compares each result transfer against
// the oldest prediction, field by field
// ----------------------------------------------------------------------------
module detection_box_transform_filter_checker
    import dbtf_pkg::*;
#(
    parameter int SCENE_RANGE = 1000,
    parameter int MAX_CLASSES = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    // left_edge, top_edge, right_edge, bottom_edge, object_id, score, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // class_index
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 s_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // box_x, box_y, box_w, box_h, centre_x, centre_y, out_id, out_score, zero pad
    input  logic [M_TDATA_W-1:0] m_tdata,
    // keep, out_class
    input  logic [M_TUSER_W-1:0] m_tuser,
    input  logic                 m_tlast,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    input  logic                 pready,
    output int                   fail_count,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    cfg_t    cfg;
    result_t pending_results[$];

    // ten-bit field of a packed box or size register
    function automatic longint field10(input logic [39:0] packed_val, input int pos);
        return longint'((packed_val >> (pos * 10)) & 40'h3FF);
    endfunction

    function automatic logic [11:0] sat12(input longint v);
        if (v > 2047)
            v = 2047;
        if (v < -2048)
            v = -2048;
        return v[11:0];
    endfunction

    // expected result of one detection under the current settings
    function automatic result_t predict_detection(input item_t it, input cfg_t c);
        longint  unit;
        longint  cunit;
        longint  xg, yg, x2g, y2g, wg, hg;
        longint  x, y, w, h, t, cx, cy;
        int      cnt;
        int      sel;
        logic    keep;
        result_t r;
        unit  = GRID_FULL;
        cunit = 2 * GRID_FULL;
        xg  = longint'(it.left_edge) + GRID_HALF;
        yg  = GRID_HALF - longint'(it.top_edge);
        x2g = longint'(it.right_edge) + GRID_HALF;
        y2g = GRID_HALF - longint'(it.bottom_edge);
        wg  = x2g - xg;
        hg  = y2g - yg;
        keep = 1'b1;

        // half turn is done on the grid
        if (c.rotation == ROT_180)
        begin
            xg = GRID_FULL - xg - wg;
            yg = GRID_FULL - yg - hg;
        end
        x = xg * SCENE_RANGE;
        y = yg * SCENE_RANGE;
        w = wg * SCENE_RANGE;
        h = hg * SCENE_RANGE;

        // quarter turns swap the axes, truncating to whole units
        if (c.rotation == ROT_90)
        begin
            t = h / unit;
            h = w;
            w = t * unit;
            t = x / unit;
            x = longint'(SCENE_RANGE) * unit - y - w;
            y = t * unit;
        end
        else if (c.rotation == ROT_270)
        begin
            t = h / unit;
            h = w;
            w = t * unit;
            t = y / unit;
            y = longint'(SCENE_RANGE) * unit - x - h;
            x = t * unit;
        end
        cx = 2 * x + w;
        cy = 2 * y + h;

        // class lookup, out of range ids fall on the last class
        cnt = int'(c.class_count);
        if (cnt < 1)
            cnt = 1;
        if (cnt > MAX_CLASSES)
            cnt = MAX_CLASSES;
        sel = (int'(it.class_index) < cnt) ? int'(it.class_index) : cnt - 1;
        if (!c.class_active_mask[sel])
            keep = 1'b0;
        if (it.score < c.min_confidence)
            keep = 1'b0;

        // size window
        if (w > field10(c.max_size, 0) * unit || h > field10(c.max_size, 1) * unit)
            keep = 1'b0;
        if (w < field10(c.min_size, 0) * unit || h < field10(c.min_size, 1) * unit)
            keep = 1'b0;

        // centre inside the area of interest
        if (cx < field10(c.area_box, 0) * cunit || cx > field10(c.area_box, 2) * cunit ||
            cy < field10(c.area_box, 1) * cunit || cy > field10(c.area_box, 3) * cunit)
            keep = 1'b0;

        // centre outside the ignore region, left edge open
        if (cx > field10(c.ignore_box, 0) * cunit && cx <= field10(c.ignore_box, 2) * cunit &&
            cy >= field10(c.ignore_box, 1) * cunit && cy <= field10(c.ignore_box, 3) * cunit)
            keep = 1'b0;

        r.keep      = keep;
        r.box_x     = sat12(x / unit);
        r.box_y     = sat12(y / unit);
        r.box_w     = sat12(w / unit);
        r.box_h     = sat12(h / unit);
        r.centre_x  = sat12(cx / cunit);
        r.centre_y  = sat12(cy / cunit);
        r.out_id    = it.object_id;
        r.out_class = it.class_index;
        r.out_score = it.score;
        r.out_last  = it.last_of_scene;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // all channels are sampled at the rising edge
    always @(posedge clk)
    begin
        item_t   it;
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            cfg        = CFG_RESET;
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // register write
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[5:3]))
                    REG_ROTATION:          cfg.rotation          = rot_t'(pwdata[1:0]);
                    REG_MIN_CONFIDENCE:    cfg.min_confidence    = pwdata[6:0];
                    REG_MIN_SIZE:          cfg.min_size          = pwdata[19:0];
                    REG_MAX_SIZE:          cfg.max_size          = pwdata[19:0];
                    REG_AREA_BOX:          cfg.area_box          = pwdata[39:0];
                    REG_IGNORE_BOX:        cfg.ignore_box        = pwdata[39:0];
                    REG_CLASS_ACTIVE_MASK: cfg.class_active_mask = pwdata[63:0];
                    REG_CLASS_COUNT:       cfg.class_count       = pwdata[6:0];
                    default: ;
                endcase
            end

            // result transfer
            if (m_tvalid && m_tready)
            begin
                got.keep      = m_tuser[0];
                got.out_class = m_tuser[8:1];
                got.box_x     = m_tdata[11:0];
                got.box_y     = m_tdata[23:12];
                got.box_w     = m_tdata[35:24];
                got.box_h     = m_tdata[47:36];
                got.centre_x  = m_tdata[59:48];
                got.centre_y  = m_tdata[71:60];
                got.out_id    = m_tdata[103:72];
                got.out_score = m_tdata[110:104];
                got.out_last  = m_tlast;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected, actual 0x%0h",
                             $time, got);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    compare_field("keep", want.keep, got.keep);
                    compare_field("box_x", want.box_x, got.box_x);
                    compare_field("box_y", want.box_y, got.box_y);
                    compare_field("box_w", want.box_w, got.box_w);
                    compare_field("box_h", want.box_h, got.box_h);
                    compare_field("centre_x", want.centre_x, got.centre_x);
                    compare_field("centre_y", want.centre_y, got.centre_y);
                    compare_field("out_id", want.out_id, got.out_id);
                    compare_field("out_class", want.out_class, got.out_class);
                    compare_field("out_score", want.out_score, got.out_score);
                    compare_field("out_last", want.out_last, got.out_last);
                end
            end

            // detection transfer
            if (s_tvalid && s_tready)
            begin
                it.left_edge     = s_tdata[13:0];
                it.top_edge      = s_tdata[27:14];
                it.right_edge    = s_tdata[41:28];
                it.bottom_edge   = s_tdata[55:42];
                it.object_id     = s_tdata[87:56];
                it.score         = s_tdata[94:88];
                it.class_index   = s_tuser[7:0];
                it.last_of_scene = s_tlast;
                pending_results.push_back(predict_detection(it, cfg));
            end
            pending = pending_results.size();
        end
    end

endmodule

// ----- dv/detection_box_transform_filter_top_test.sv -----
// ----------------------------------------------------------------------------
// detection_box_transform_filter_top_test
// drives detections and register writes into the block under several
// settings and idle patterns, the checker beside it predicts and compares
// ----------------------------------------------------------------------------
module detection_box_transform_filter_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import dbtf_pkg::*;

    localparam int SCENE_RANGE = 1000;
    localparam int MAX_CLASSES = 64;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 100;
    localparam int HOLD_CYCLES = 300;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;

    always #5 clk = ~clk;

    detection_box_transform_filter_top #(
        .SCENE_RANGE (SCENE_RANGE),
        .MAX_CLASSES (MAX_CLASSES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    detection_box_transform_filter_checker #(
        .SCENE_RANGE (SCENE_RANGE),
        .MAX_CLASSES (MAX_CLASSES)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // receiver: random stalls, or a long hold-off when requested
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // run limit
    initial
    begin
        #2000000;
        $display("detection_box_transform_filter_top_test failed");
        $finish;
    end

    function automatic item_t make_item(input int l, input int t, input int r, input int b,
                                        input logic [31:0] id, input int cls,
                                        input int sc, input logic last);
        item_t it;
        it.left_edge     = 14'(l);
        it.top_edge      = 14'(t);
        it.right_edge    = 14'(r);
        it.bottom_edge   = 14'(b);
        it.object_id     = id;
        it.class_index   = 8'(cls);
        it.score         = 7'(sc);
        it.last_of_scene = last;
        return it;
    endfunction

    // mostly ordered boxes inside the frame, some raw edge values
    function automatic item_t random_item();
        int a, b, c, d;
        int cls, sc;
        if ($urandom_range(0, 4) != 0)
        begin
            a = int'($urandom_range(0, 8192)) - 4096;
            b = int'($urandom_range(0, 8192)) - 4096;
            c = int'($urandom_range(0, 8192)) - 4096;
            d = int'($urandom_range(0, 8192)) - 4096;
            if (a > b)
            begin
                a = a ^ b; b = a ^ b; a = a ^ b;
            end
            if (d > c)
            begin
                c = c ^ d; d = c ^ d; c = c ^ d;
            end
        end
        else
        begin
            a = int'($urandom_range(0, 16383));
            b = int'($urandom_range(0, 16383));
            c = int'($urandom_range(0, 16383));
            d = int'($urandom_range(0, 16383));
        end
        cls = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 255))
                                          : int'($urandom_range(0, 70));
        sc  = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 127))
                                          : int'($urandom_range(0, 100));
        return make_item(a, c, b, d, $urandom, cls, sc, 1'(($urandom_range(0, 3) == 0)));
    endfunction

    // called and returning at a falling edge, valid stays high after the transfer
    task automatic send_item(input item_t it);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, it.score, it.object_id, it.bottom_edge, it.right_edge,
                     it.top_edge, it.left_edge};
        s_tuser  <= it.class_index;
        s_tlast  <= it.last_of_scene;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // stop offering and wait for every expected result plus the pipeline depth
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // kind 0 all zero, 1 all ones, 2 raw random, else shaped settings
    task automatic load_config(input int kind, input int rot);
        logic [63:0] v[8];
        logic [9:0]  x1, y1;
        case (kind)
            0: v = '{default: 64'd0};
            1: v = '{64'd3, 64'd127, 64'hFFFFF, 64'hFFFFF, 64'hFF_FFFF_FFFF,
                     64'hFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'd127};
            2:
            begin
                foreach (v[i])
                    v[i] = {$urandom, $urandom};
            end
            default:
            begin
                x1 = 10'($urandom_range(0, 900));
                y1 = 10'($urandom_range(0, 900));
                v[REG_ROTATION]       = 64'(rot);
                v[REG_MIN_CONFIDENCE] = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(101, 127))
                                                                    : 64'($urandom_range(0, 100));
                v[REG_MIN_SIZE]       = 64'({10'($urandom_range(0, 80)),
                                             10'($urandom_range(0, 80))});
                v[REG_MAX_SIZE]       = 64'({10'($urandom_range(400, 1023)),
                                             10'($urandom_range(400, 1023))});
                v[REG_AREA_BOX]       = 64'({10'($urandom_range(600, 1023)),
                                             10'($urandom_range(600, 1023)),
                                             10'($urandom_range(0, 400)),
                                             10'($urandom_range(0, 400))});
                v[REG_IGNORE_BOX]     = 64'({10'(y1 + 10'($urandom_range(0, 120))),
                                             10'(x1 + 10'($urandom_range(0, 120))), y1, x1});
                v[REG_CLASS_ACTIVE_MASK] = ($urandom_range(0, 3) == 0)
                                           ? {$urandom, $urandom}
                                           : {$urandom | $urandom, $urandom | $urandom};
                v[REG_CLASS_COUNT]    = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(0, 127))
                                                                    : 64'($urandom_range(1, 64));
            end
        endcase
        for (int i = 0; i < 8; i++)
            write_reg(reg_idx_t'(i), v[i]);
    endtask

    // stimulus and verdict
    initial
    begin
        item_t directed[6];
        directed[0] = make_item(-4096, 4096, 4096, -4096, 32'h0, 0, 100, 1'b1);
        directed[1] = make_item(0, 0, 0, 0, 32'hFFFF_FFFF, 255, 0, 1'b0);
        directed[2] = make_item(4096, -4096, -4096, 4096, 32'h5555_AAAA, 64, 100, 1'b1);
        directed[3] = make_item(-8192, 8191, 8191, -8192, 32'hAAAA_5555, 63, 127, 1'b0);
        directed[4] = make_item(-1000, 500, 1500, -2000, 32'h1234_5678, 128, 50, 1'b1);
        directed[5] = make_item(8191, -8192, -8192, 8191, 32'h8000_0001, 1, 1, 1'b0);

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed items at reset settings, once per rotation
        send_idle_pct = 36;
        recv_idle_pct = 62;
        for (int rot = 0; rot < 4; rot++)
        begin
            write_reg(REG_ROTATION, 64'(rot));
            foreach (directed[i])
                send_item(directed[i]);
        end

        // random phases under changing settings and idle patterns
        for (int p = 0; p < PHASES; p++)
        begin
            if (p < 4)
            begin
                send_idle_pct = 36;
                recv_idle_pct = 62;
            end
            else if (p < 8)
            begin
                send_idle_pct = 62;
                recv_idle_pct = 36;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            load_config((p < 3) ? p : 3, p % 4);
            wait_idle();

            // long receiver hold-off while items keep coming
            if (p == 8)
            begin
                @(posedge clk);
                hold_left = HOLD_CYCLES;
                @(negedge clk);
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(random_item());
        end

        wait_idle();
        repeat (10) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("detection_box_transform_filter_top_test passed");
        else
            $display("detection_box_transform_filter_top_test failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/dbtf_pkg.sv
rtl/dbtf_cfg.sv
rtl/dbtf_core.sv
rtl/detection_box_transform_filter_top.sv
dv/detection_box_transform_filter_checker.sv
dv/detection_box_transform_filter_top_test.sv
